@@ sv/sgdm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdm_pkg
// Shared types, constants and rounding helpers of the SGD momentum update core.
// ----------------------------------------------------------------------------
package sgdm_pkg;

	localparam int SLOT_COUNT = 4096;
	localparam int SLOT_W     = 12;
	localparam int ITER_W     = 20;
	localparam int VAL_W      = 32;
	localparam int LR_W       = 16;
	localparam int MOM_W      = 16;
	localparam int DECAY_W    = 24;
	localparam int DEN_W      = 45;
	localparam int RATE_W     = 32;
	localparam int DIV_STAGES = RATE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int WIDE_W     = 36;

	localparam logic [LR_W-1:0] LR_RESET = 16'd655;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_RATE = 2'd0,
		REG_MOMENTUM  = 2'd1,
		REG_DECAY     = 2'd2,
		REG_NESTEROV  = 2'd3
	} cfg_reg_t;

	// one item in flight through the rate divider
	typedef struct packed {
		logic [SLOT_W-1:0]       slot;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] grad;
		logic [DEN_W-1:0]        den;
		logic [DEN_W-1:0]        rem;
		logic [RATE_W-1:0]       q;
	} div_item_t;

	typedef struct packed {
		logic                    clip;
		logic signed [VAL_W-1:0] v;
	} sat_t;

	// magnitude of a signed word; the most negative value maps to 2^31
	function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] x);
		logic [VAL_W-1:0] u;
		u = x;
		return x[VAL_W-1] ? (VAL_W'(0) - u) : u;
	endfunction

	// (p + 2^31) >> 32
	function automatic logic [32:0] rnd32(input logic [63:0] p);
		logic [64:0] t;
		t = {1'b0, p} + 65'h0_8000_0000;
		return t[64:32];
	endfunction

	// (p + 2^15) >> 16
	function automatic logic [32:0] rnd16(input logic [47:0] p);
		logic [48:0] t;
		t = {1'b0, p} + 49'h0_8000;
		return t[48:16];
	endfunction

	function automatic logic signed [WIDE_W-1:0] apply_sign(input logic neg,
			input logic [32:0] m);
		logic signed [WIDE_W-1:0] s;
		s = $signed({3'b000, m});
		return neg ? -s : s;
	endfunction

	function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
		sat_t r;
		r.clip = 1'b0;
		r.v = v[VAL_W-1:0];
		if (v > WIDE_W'(64'sh7FFF_FFFF)) begin
			r.clip = 1'b1;
			r.v = 32'sh7FFF_FFFF;
		end else if (v < -WIDE_W'(64'sh8000_0000)) begin
			r.clip = 1'b1;
			r.v = 32'sh8000_0000;
		end
		return r;
	endfunction

endpackage

@@ sv/sgdm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdm_in_if / sgdm_out_if
// Valid/ready channels carrying update items and result items.
// ----------------------------------------------------------------------------
interface sgdm_in_if;
	logic               valid;
	logic               ready;
	logic [11:0]        slot_index;
	logic [19:0]        iteration;
	logic signed [31:0] param_value;
	logic signed [31:0] gradient;

	modport source (output valid, slot_index, iteration, param_value, gradient,
		input ready);
	modport sink (input valid, slot_index, iteration, param_value, gradient,
		output ready);
endinterface

interface sgdm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_value;
	logic               saturated;

	modport source (output valid, new_value, saturated, input ready);
	modport sink (input valid, new_value, saturated, output ready);
endinterface

@@ sv/sgd_momentum_param_update_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_momentum_param_update_core
// SGD update with momentum, Nesterov option and iteration rate decay.
// ----------------------------------------------------------------------------
//  port      | dir | contents
//  upd_in    | in  | slot_index, iteration, param_value, gradient
//  upd_out   | out | new_value, saturated
//  cfg_*     | in  | write enable, register index, data
//
// One item per cycle unless stalled; path: divider, s1 to s4, output register.
// The rate comes from a 32-stage restoring divider, one quotient bit a stage.
// Velocity lives in a 4096-entry RAM, read one stage before the update and
// written back at its end; the entry written in the same cycle is forwarded.
// After reset a clearing pass zeroes all 4096 RAM entries, ready held low.
// A stalled output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module sgd_momentum_param_update_core import sgdm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sgdm_in_if.sink               upd_in,
	sgdm_out_if.source            upd_out
);

	logic [LR_W-1:0]    base_rate_q;
	logic [MOM_W-1:0]   momentum_q;
	logic [DECAY_W-1:0] decay_q;
	logic               nesterov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_rate_q <= LR_RESET;
			momentum_q  <= '0;
			decay_q     <= '0;
			nesterov_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BASE_RATE: base_rate_q <= cfg_data[LR_W-1:0];
				REG_MOMENTUM:  momentum_q <= cfg_data[MOM_W-1:0];
				REG_DECAY:     decay_q <= cfg_data[DECAY_W-1:0];
				REG_NESTEROV:  nesterov_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic mom_on;
	assign mom_on = (momentum_q != '0);

	// clearing pass
	logic              clr_q;
	logic [SLOT_W-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == SLOT_W'(SLOT_COUNT - 1))
				clr_q <= 1'b0;
		end
	end

	logic out_valid_q;
	logic en;
	logic accept;
	assign en = !out_valid_q || upd_out.ready;
	assign upd_in.ready = en && !clr_q;
	assign accept = upd_in.valid && upd_in.ready;

	// rate divider: (base rate << 40) / (2^24 + decay * iteration)
	logic      dv_valid_s [0:DIV_STAGES];
	div_item_t dv_s [0:DIV_STAGES];
	div_item_t dv_n [1:DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_valid_s[0] <= 1'b0;
		end else if (en) begin
			dv_valid_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].slot  <= upd_in.slot_index;
			dv_s[0].value <= upd_in.param_value;
			dv_s[0].grad  <= upd_in.gradient;
			dv_s[0].den   <= DEN_W'(45'd1 << 24)
				+ DEN_W'(decay_q) * DEN_W'(upd_in.iteration);
			dv_s[0].rem   <= {21'd0, base_rate_q, 8'd0};
			dv_s[0].q     <= '0;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [DEN_W:0] r2;
		logic [DEN_W:0] diff;
		logic           ge;

		always_comb begin
			r2   = {dv_s[k].rem, 1'b0};
			diff = r2 - {1'b0, dv_s[k].den};
			ge   = (r2 >= {1'b0, dv_s[k].den});
			dv_n[k+1]     = dv_s[k];
			dv_n[k+1].rem = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
			dv_n[k+1].q   = {dv_s[k].q[RATE_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_valid_s[k+1] <= dv_valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				dv_s[k+1] <= dv_n[k+1];
		end
	end

	// s1: gradient times rate
	logic                    valid_s1;
	logic [SLOT_W-1:0]       slot_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic                    neg_s1;
	logic [63:0]             prod_s1;

	// s2: velocity read data ready, new velocity formed and written
	logic                     valid_s2;
	logic [SLOT_W-1:0]        slot_s2;
	logic signed [VAL_W-1:0]  value_s2;
	logic signed [WIDE_W-1:0] step_s2;
	logic signed [VAL_W-1:0]  rdata_s2;

	// s3: Nesterov product
	logic                     valid_s3;
	logic [SLOT_W-1:0]        slot_s3;
	logic signed [VAL_W-1:0]  value_s3;
	logic signed [WIDE_W-1:0] step_s3;
	logic signed [VAL_W-1:0]  nv_s3;
	logic                     clip_s3;

	// s4: final sum
	logic                     valid_s4;
	logic signed [VAL_W-1:0]  value_s4;
	logic signed [WIDE_W-1:0] step_s4;
	logic signed [VAL_W-1:0]  nv_s4;
	logic                     nvneg_s4;
	logic [47:0]              prod2_s4;
	logic                     clip_s4;

	logic signed [VAL_W-1:0] new_value_q;
	logic                    saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= dv_valid_s[DIV_STAGES];
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1  <= dv_s[DIV_STAGES].slot;
			value_s1 <= dv_s[DIV_STAGES].value;
			neg_s1   <= dv_s[DIV_STAGES].grad[VAL_W-1];
			prod_s1  <= {32'd0, mag32(dv_s[DIV_STAGES].grad)} * {32'd0, dv_s[DIV_STAGES].q};
		end
	end

	logic signed [WIDE_W-1:0] step_c1;
	assign step_c1 = apply_sign(neg_s1, rnd32(prod_s1));

	logic signed [VAL_W-1:0] vmem [0:SLOT_COUNT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s2  <= slot_s1;
			value_s2 <= value_s1;
			step_s2  <= step_c1;
			rdata_s2 <= vmem[slot_s1];
		end
	end

	// the entry written at the read edge sits in s3: forward it
	logic signed [VAL_W-1:0]  vel_c2;
	logic [47:0]              mprod_c2;
	logic signed [WIDE_W-1:0] diff_c2;
	sat_t                     nv_c2;
	logic                     wr_c2;

	always_comb begin
		vel_c2 = (valid_s3 && slot_s3 == slot_s2) ? nv_s3 : rdata_s2;
		mprod_c2 = {16'd0, mag32(vel_c2)} * {32'd0, momentum_q};
		diff_c2 = apply_sign(vel_c2[VAL_W-1], rnd16(mprod_c2)) - step_s2;
		nv_c2 = sat32(diff_c2);
		wr_c2 = valid_s2 && mom_on && en;
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			vmem[clr_cnt_q] <= '0;
		else if (wr_c2)
			vmem[slot_s2] <= nv_c2.v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s3 forwards whenever valid; without momentum it holds the value read
			slot_s3  <= slot_s2;
			value_s3 <= value_s2;
			step_s3  <= step_s2;
			nv_s3    <= mom_on ? nv_c2.v : rdata_s2;
			clip_s3  <= mom_on && nv_c2.clip;

			value_s4 <= value_s3;
			step_s4  <= step_s3;
			nv_s4    <= nv_s3;
			nvneg_s4 <= nv_s3[VAL_W-1];
			prod2_s4 <= {16'd0, mag32(nv_s3)} * {32'd0, momentum_q};
			clip_s4  <= clip_s3;
		end
	end

	logic signed [WIDE_W-1:0] incr_c4;
	logic signed [WIDE_W-1:0] sum_c4;
	sat_t                     res_c4;

	always_comb begin
		if (!mom_on)
			incr_c4 = -step_s4;
		else if (nesterov_q)
			incr_c4 = apply_sign(nvneg_s4, rnd16(prod2_s4)) - step_s4;
		else
			incr_c4 = WIDE_W'(nv_s4);
		sum_c4 = WIDE_W'(value_s4) + incr_c4;
		res_c4 = sat32(sum_c4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_value_q <= res_c4.v;
			saturated_q <= clip_s4 || res_c4.clip;
		end
	end

	assign upd_out.valid     = out_valid_q;
	assign upd_out.new_value = new_value_q;
	assign upd_out.saturated = saturated_q;

endmodule

@@ tb/tb_sgd_momentum_param_update_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sgd_momentum_param_update_core
// Streams update items through the core under several rate, momentum, decay
// and Nesterov settings, with random stalls on both sides, and compares each
// result item against a bit-exact fixed-point model of the update.
// ----------------------------------------------------------------------------
module tb_sgd_momentum_param_update_core;
	import sgdm_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0]       slot;
		logic [ITER_W-1:0]       iter;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] grad;
	} upd_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    clip;
	} upd_res_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sgdm_in_if  in_ch();
	sgdm_out_if out_ch();

	sgd_momentum_param_update_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .upd_in(in_ch.sink), .upd_out(out_ch.source)
	);

	// model state
	logic [15:0] m_rate;
	logic [15:0] m_mom;
	logic [23:0] m_decay;
	logic        m_nest;
	logic signed [31:0] m_vel [SLOT_COUNT];

	upd_item_t pending_items[$];
	upd_res_t  expected_results[$];
	int errors;
	bit quiet_tx;      // no idling stretch
	bit rx_hold_req;
	bit tx_pause;
	int watchdog;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint round_scale(longint x, longint unsigned f, int s);
		bit neg;
		longint unsigned mag;
		neg = x < 0;
		mag = neg ? (64'd0 - longint'(x)) : x;
		mag = mag * f;
		mag = (mag + (64'd1 << (s - 1))) >> s;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint clip32(longint v, ref bit c);
		if (v > 64'sd2147483647) begin
			c = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			c = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic upd_res_t predict_update(upd_item_t it);
		longint unsigned rate, den;
		longint step, vel, nv, res;
		bit c;
		upd_res_t r;
		c = 0;
		if (m_decay != 0) begin
			den = (64'd1 << 24) + longint'(m_decay) * it.iter;
			rate = (longint'(m_rate) << 40) / den;
		end else begin
			rate = longint'(m_rate) << 16;
		end
		step = round_scale(longint'(it.grad), rate, 32);
		if (m_mom == 0) begin
			res = longint'(it.value) - step;
		end else begin
			vel = m_vel[it.slot];
			nv = clip32(round_scale(vel, m_mom, 16) - step, c);
			m_vel[it.slot] = nv[31:0];
			if (m_nest)
				res = longint'(it.value) + round_scale(nv, m_mom, 16) - step;
			else
				res = longint'(it.value) + nv;
		end
		res = clip32(res, c);
		r.value = res[31:0];
		r.clip = c;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.slot_index <= '0;
			in_ch.iteration <= '0;
			in_ch.param_value <= '0;
			in_ch.gradient <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(predict_update(pending_items.pop_front()));
			end
			if ((!in_ch.valid || in_ch.ready)) begin
				if (pending_items.size() != 0 && !tx_pause
						&& (quiet_tx || $urandom_range(99) >= 10)) begin
					in_ch.valid <= 1'b1;
					in_ch.slot_index <= pending_items[0].slot;
					in_ch.iteration <= pending_items[0].iter;
					in_ch.param_value <= pending_items[0].value;
					in_ch.gradient <= pending_items[0].grad;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver stalls and long hold-off
	int hold_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_cnt <= 0;
		end else if (rx_hold_req && hold_cnt < 300) begin
			hold_cnt <= hold_cnt + 1;
			out_ch.ready <= 1'b0;
		end else begin
			if (!rx_hold_req) hold_cnt <= 0;
			out_ch.ready <= quiet_tx || ($urandom_range(99) >= 10);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				watchdog <= 0;
			else
				watchdog <= watchdog + 1;
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result value %h sat %b", $time,
						out_ch.new_value, out_ch.saturated);
					errors++;
				end else begin
					if (out_ch.new_value !== expected_results[0].value) begin
						$display("%0t: new_value expected %h actual %h", $time,
							expected_results[0].value, out_ch.new_value);
						errors++;
					end
					if (out_ch.saturated !== expected_results[0].clip) begin
						$display("%0t: saturated expected %b actual %b", $time,
							expected_results[0].clip, out_ch.saturated);
						errors++;
					end
					void'(expected_results.pop_front());
				end
			end
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("sgd_momentum_param_update_core test failed");
				$finish;
			end
		end else begin
			watchdog <= 0;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			REG_BASE_RATE: m_rate = d[15:0];
			REG_MOMENTUM:  m_mom = d[15:0];
			REG_DECAY:     m_decay = d;
			REG_NESTEROV:  m_nest = d[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		while (pending_items.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(131072) - 65536;
			3: return $urandom_range(16 << 16) - (8 << 16);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_item(logic [11:0] s, logic [19:0] it, logic [31:0] v,
			logic [31:0] g);
		upd_item_t x;
		x.slot = s;
		x.iter = it;
		x.value = v;
		x.grad = g;
		pending_items.push_back(x);
	endtask

	task automatic random_phase(int n, bit few_slots);
		repeat (n)
			push_item(few_slots ? 12'($urandom_range(7)) : 12'($urandom),
				($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(64)),
				rand_val(), rand_val());
	endtask

	initial begin
		errors = 0;
		quiet_tx = 0;
		rx_hold_req = 0;
		tx_pause = 0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE_RATE;
		cfg_data = '0;
		m_rate = LR_RESET;
		m_mom = 0;
		m_decay = 0;
		m_nest = 0;
		foreach (m_vel[i]) m_vel[i] = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: plain update at reset settings, field extremes
		push_item(12'h000, 20'h00000, 32'h0000_0000, 32'h0000_0000);
		push_item(12'hFFF, 20'hFFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		push_item(12'h001, 20'h00001, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(12'h002, 20'h12345, 32'h0001_0000, 32'hFFFF_0000);
		drain();

		// directed: max rate, classic momentum, saturating paths
		write_reg(REG_BASE_RATE, 24'hFFFF);
		write_reg(REG_MOMENTUM, 24'hFFFF);
		push_item(12'h005, 20'h0, 32'h7FFF_FFFF, 32'h8000_0000);
		push_item(12'h005, 20'h0, 32'h7FFF_FFFF, 32'h8000_0000);
		push_item(12'h005, 20'h0, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(12'hFFF, 20'h0, 32'h0000_8000, 32'h0000_0001);
		push_item(12'h006, 20'h0, 32'h0, 32'hFFFF_FFFF);
		drain();

		// directed: Nesterov with maximum decay
		write_reg(REG_NESTEROV, 24'h1);
		write_reg(REG_DECAY, 24'hFFFFFF);
		push_item(12'h005, 20'hFFFFF, 32'h1234_5678, 32'h8000_0000);
		push_item(12'h006, 20'h00001, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(12'h007, 20'h00000, 32'h0, 32'h7FFF_FFFF);
		drain();

		// random: Nesterov, moderate momentum, decay; long receiver hold-off
		write_reg(REG_MOMENTUM, 24'h E000);
		write_reg(REG_DECAY, 24'h000100);
		random_phase(150, 1);
		rx_hold_req = 1;
		repeat (300) @(posedge clk);
		rx_hold_req = 0;
		drain();

		// random: classic momentum, no idling stretch
		write_reg(REG_NESTEROV, 24'h0);
		write_reg(REG_DECAY, 24'h0);
		write_reg(REG_BASE_RATE, 24'h1000);
		quiet_tx = 1;
		random_phase(150, 1);
		drain();
		quiet_tx = 0;

		// random: plain update, zero rate then random rate; sender pause
		write_reg(REG_MOMENTUM, 24'h0);
		write_reg(REG_BASE_RATE, 24'h0);
		random_phase(60, 0);
		drain();
		write_reg(REG_BASE_RATE, 24'($urandom_range(65535)));
		write_reg(REG_DECAY, 24'($urandom));
		random_phase(130, 0);
		// let items get under way before pausing the sender
		repeat (60) @(posedge clk);
		tx_pause = 1;
		while (expected_results.size() != 0 || in_ch.valid) @(posedge clk);
		repeat (20) @(posedge clk);
		tx_pause = 0;
		drain();

		// random: momentum with random settings
		write_reg(REG_MOMENTUM, 24'($urandom_range(65535, 1)));
		write_reg(REG_NESTEROV, 24'($urandom_range(1)));
		write_reg(REG_BASE_RATE, 24'($urandom_range(65535)));
		random_phase(240, 1);
		drain();

		if (errors == 0)
			$display("sgd_momentum_param_update_core test passed");
		else
			$display("sgd_momentum_param_update_core test failed");
		$finish;
	end

endmodule

@@ sim.f @@
sv/sgdm_pkg.sv
sv/sgdm_if.sv
sv/sgd_momentum_param_update_core.sv
tb/tb_sgd_momentum_param_update_core.sv
